// ===== design/fpsa_pkg.sv =====
// Shared constants for the five-point stencil average unit.
// Holds the configuration register map and the fixed field widths.
// No dependencies.
package fpsa_pkg;

	// Configuration port layout.
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 13;

	localparam int GRID_WIDTH_BITS = 11;
	localparam int GRID_HEIGHT_BITS = 13;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [GRID_WIDTH_BITS-1:0] GRID_WIDTH_RESET = 11'd1024;
	localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 13'd1024;

	// Smallest grid edge that is honored.
	localparam int MIN_GRID = 3;

	// Result queue in front of the output channel.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_CNT_BITS = 3;

endpackage

// ===== design/five_point_stencil_average_unit.sv =====
// Five-point stencil smoother over a raster-order sample stream.
// Depends on fpsa_pkg for the register map and the result queue size.
//
// The unit accepts one sample per clock cycle in raster order while in_stall is
// low and returns each sample replaced by the rounded mean of itself and its
// four orthogonal neighbors; border rows and columns pass through unchanged.
// Results for a row come out while the following row streams in, so a row
// produces nothing until the next one arrives; every sample of the last row
// also returns itself as a second result, and last_of_run marks the final
// result of each item. The two previous rows live in two single-port line
// memories of MAX_WIDTH entries each, read and written once per item, so items
// flow at one per cycle unless stalled. As the last row yields two results per
// item and the output takes at most one per cycle, in_stall throttles the last
// row. The line memories need no clearing after reset. Grid size registers may
// be written only while no item is in flight.
module five_point_stencil_average_unit
	import fpsa_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_value,
	output logic [$clog2(MAX_HEIGHT)-1:0] out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
	output logic                          last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SB = SAMPLE_BITS;
	localparam int WWB = (CW + 1 > GRID_WIDTH_BITS) ? CW + 1 : GRID_WIDTH_BITS;
	localparam int HWB = (RW + 1 > GRID_HEIGHT_BITS) ? RW + 1 : GRID_HEIGHT_BITS;

	// Divide by five as a multiply by a scaled reciprocal. The magnitude
	// has N bits; with S = N + 2 the floor of m*K >> S is exact.
	localparam int N = SB + 3;
	localparam int S = N + 2;
	localparam int H = (N + 1) / 2;
	localparam logic [63:0] K_WIDE = ((64'd1 << S) + 64'd4) / 64'd5;
	localparam logic [N-1:0] K = K_WIDE[N-1:0];
	localparam logic [H-1:0] K_LO = K[H-1:0];
	localparam logic [N-H-1:0] K_HI = K[N-1:H];

	typedef struct packed {
		logic signed [SB-1:0] value;
		logic [RW-1:0]        row;
		logic [CW-1:0]        col;
		logic                 last;
	} res_t;

	// ---------------------------------------------------------------
	// Configuration and raster position.
	logic [GRID_WIDTH_BITS-1:0]  grid_width_q;
	logic [GRID_HEIGHT_BITS-1:0] grid_height_q;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic                        line_swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RESET;
			grid_height_q <= GRID_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH: grid_width_q <= cfg_data[GRID_WIDTH_BITS-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[GRID_HEIGHT_BITS-1:0];
			endcase
		end
	end

	logic [WWB-1:0] w_ext, w_use;
	logic [HWB-1:0] h_ext, h_use;
	logic [CW-1:0]  w_last, c_cur;
	logic [RW-1:0]  h_last, r_cur;
	logic           last_col, last_row;
	logic [CW:0]    c_plus1;
	logic           right_zero;
	logic [CW-1:0]  c_right;

	always_comb begin
		w_ext = WWB'(grid_width_q);
		h_ext = HWB'(grid_height_q);
		if (w_ext < WWB'(MIN_GRID))
			w_use = WWB'(MIN_GRID);
		else if (w_ext > WWB'(MAX_WIDTH))
			w_use = WWB'(MAX_WIDTH);
		else
			w_use = w_ext;
		if (h_ext < HWB'(MIN_GRID))
			h_use = HWB'(MIN_GRID);
		else if (h_ext > HWB'(MAX_HEIGHT))
			h_use = HWB'(MAX_HEIGHT);
		else
			h_use = h_ext;
		w_last = CW'(w_use - WWB'(1));
		h_last = RW'(h_use - HWB'(1));
		c_cur = (col_q >= w_last) ? w_last : col_q;
		r_cur = (row_q >= h_last) ? h_last : row_q;
		last_col = (c_cur == w_last);
		last_row = (r_cur == h_last);
		c_plus1 = {1'b0, c_cur} + (CW + 1)'(1);
		right_zero = (c_plus1 == (CW + 1)'(MAX_WIDTH));
		c_right = right_zero ? '0 : c_plus1[CW-1:0];
	end

	// ---------------------------------------------------------------
	// Pipeline control. Every stage moves together while the result queue
	// has room for the two results that the oldest item may produce.
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic adv, accept;

	assign adv = (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign in_stall = !adv;
	assign accept = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			line_swap_q <= 1'b0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				line_swap_q <= !line_swap_q;
				row_q <= last_row ? '0 : r_cur + RW'(1);
			end else begin
				col_q <= c_cur + CW'(1);
				row_q <= r_cur;
			end
		end
	end

	// ---------------------------------------------------------------
	// Line memories. The bank that holds the older row is read at the
	// current column and then overwritten with the new sample; the other
	// bank is read one column ahead. Entry zero of each bank is mirrored
	// in a register, which gives the first column its center value.
	logic signed [SB-1:0] mem_a [MAX_WIDTH];
	logic signed [SB-1:0] mem_b [MAX_WIDTH];
	logic signed [SB-1:0] row0_a_q, row0_b_q;
	logic signed [SB-1:0] rd_a_s1, rd_b_s1;
	logic [CW-1:0]        addr_a, addr_b;

	assign addr_a = line_swap_q ? c_right : c_cur;
	assign addr_b = line_swap_q ? c_cur : c_right;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_s1 <= mem_a[addr_a];
			rd_b_s1 <= mem_b[addr_b];
			if (!line_swap_q) begin
				mem_a[c_cur] <= sample;
				if (c_cur == '0)
					row0_a_q <= sample;
			end else begin
				mem_b[c_cur] <= sample;
				if (c_cur == '0)
					row0_b_q <= sample;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: item position and memory data; form the five-term sum.
	logic                 v1_q;
	logic signed [SB-1:0] x_s1, ctr0_s1;
	logic [CW-1:0]        c_s1;
	logic [RW-1:0]        r_s1;
	logic                 lastcol_s1, lastrow_s1, swap_s1, rz_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= sample;
			c_s1 <= c_cur;
			r_s1 <= r_cur;
			lastcol_s1 <= last_col;
			lastrow_s1 <= last_row;
			swap_s1 <= line_swap_q;
			rz_s1 <= right_zero;
			ctr0_s1 <= line_swap_q ? row0_a_q : row0_b_q;
		end
	end

	logic signed [SB-1:0] lcw_left_q, lcw_center_q;
	logic signed [SB-1:0] up1, right1, center1, left1;
	logic signed [N-1:0]  sum1;
	logic                 copy1;

	always_comb begin
		up1 = swap_s1 ? rd_b_s1 : rd_a_s1;
		right1 = rz_s1 ? '0 : (swap_s1 ? rd_a_s1 : rd_b_s1);
		center1 = (c_s1 == '0) ? ctr0_s1 : lcw_center_q;
		left1 = lcw_left_q;
		sum1 = N'(center1) + N'(left1) + N'(right1) + N'(up1) + N'(x_s1);
		copy1 = (r_s1 == RW'(1)) || (c_s1 == '0) || lastcol_s1;
	end

	// Left and center neighbors slide along the newer row, one step per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcw_left_q <= '0;
			lcw_center_q <= '0;
		end else if (adv && v1_q) begin
			lcw_left_q <= center1;
			lcw_center_q <= right1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: magnitude plus rounding offset, partial products.
	logic                 v2_q;
	logic signed [N-1:0]  sum_s2;
	logic signed [SB-1:0] center_s2, x_s2;
	logic                 copy_s2, emit1_s2, emit2_s2;
	logic [CW-1:0]        c_s2;
	logic [RW-1:0]        r_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum1;
			center_s2 <= center1;
			x_s2 <= x_s1;
			copy_s2 <= copy1;
			emit1_s2 <= (r_s1 != '0);
			emit2_s2 <= lastrow_s1;
			c_s2 <= c_s1;
			r_s2 <= r_s1;
		end
	end

	logic           neg2;
	logic [N-1:0]   mag2;
	logic [H-1:0]   m_lo2;
	logic [N-H-1:0] m_hi2;

	always_comb begin
		neg2 = sum_s2[N-1];
		mag2 = (neg2 ? N'(-sum_s2) : N'(sum_s2)) + N'(2);
		m_lo2 = mag2[H-1:0];
		m_hi2 = mag2[N-1:H];
	end

	// ---------------------------------------------------------------
	// Stage 3: combine partial products, scale, restore the sign.
	logic                 v3_q;
	logic [2*H-1:0]       pp_ll_s3;
	logic [N-1:0]         pp_lh_s3, pp_hl_s3;
	logic [2*(N-H)-1:0]   pp_hh_s3;
	logic                 neg_s3, copy_s3, emit1_s3, emit2_s3;
	logic signed [SB-1:0] center_s3, x_s3;
	logic [CW-1:0]        c_s3;
	logic [RW-1:0]        r_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_ll_s3 <= m_lo2 * K_LO;
			pp_lh_s3 <= N'(m_lo2 * K_HI);
			pp_hl_s3 <= N'(m_hi2 * K_LO);
			pp_hh_s3 <= m_hi2 * K_HI;
			neg_s3 <= neg2;
			copy_s3 <= copy_s2;
			emit1_s3 <= emit1_s2;
			emit2_s3 <= emit2_s2;
			center_s3 <= center_s2;
			x_s3 <= x_s2;
			c_s3 <= c_s2;
			r_s3 <= r_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= in_valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	logic [2*N-1:0]       prod3;
	logic [SB-1:0]        q3;
	logic signed [SB-1:0] value3;
	res_t                 res_mid, res_border;

	always_comb begin
		prod3 = {pp_hh_s3, pp_ll_s3}
			+ (((2 * N)'(pp_lh_s3) + (2 * N)'(pp_hl_s3)) << H);
		q3 = prod3[S +: SB];
		if (copy_s3)
			value3 = center_s3;
		else
			value3 = neg_s3 ? -q3 : q3;
		res_mid.value = value3;
		res_mid.row = r_s3 - RW'(1);
		res_mid.col = c_s3;
		res_mid.last = !emit2_s3;
		res_border.value = x_s3;
		res_border.row = r_s3;
		res_border.col = c_s3;
		res_border.last = 1'b1;
	end

	// ---------------------------------------------------------------
	// Result queue. An item of the last row pushes two results at once.
	res_t                     fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic                     push_any, pop;
	logic [1:0]               n_push;

	always_comb begin
		push_any = adv && v3_q;
		n_push = 2'(push_any && emit1_s3) + 2'(push_any && emit2_s3);
		pop = out_valid && !out_stall;
	end

	always_ff @(posedge clk) begin
		if (push_any) begin
			if (emit1_s3) begin
				fifo_q[wr_ptr_q] <= res_mid;
				if (emit2_s3)
					fifo_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= res_border;
			end else if (emit2_s3) begin
				fifo_q[wr_ptr_q] <= res_border;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			count_q <= count_q + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(pop);
		end
	end

	assign out_valid = (count_q != '0);
	assign out_value = fifo_q[rd_ptr_q].value;
	assign out_row = fifo_q[rd_ptr_q].row;
	assign out_col = fifo_q[rd_ptr_q].col;
	assign last_of_run = fifo_q[rd_ptr_q].last;

	// ---------------------------------------------------------------
	// Checks.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col |=> col_q == '0)
		else $error("column did not wrap after the last column");

	a_swap_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(line_swap_q) |-> $past(accept && last_col))
		else $error("line banks swapped outside a row end");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v3_q) && $stable(v1_q))
		else $error("pipeline moved while the result queue was full");

endmodule
